@@ src/ccw_pkg.sv @@
package ccw_pkg;

  localparam int MaxNodes    = 64;
  localparam int FracBits    = 30;
  localparam int CountW      = 7;
  localparam int IndexW      = 6;
  localparam int WeightW     = 31;
  localparam int SumDepth    = MaxNodes / 2 + 1;
  localparam int AddrW       = $clog2(SumDepth);
  localparam int HalfW       = $clog2(MaxNodes / 2);
  localparam int SumW        = 40;
  localparam int ChebW       = 34;
  localparam int AngW        = 33;
  localparam int CordicSteps = FracBits + 2;
  localparam int StepW       = $clog2(CordicSteps);
  localparam int DivNW       = 37;
  localparam int DivDW       = 2 * HalfW + 2;
  localparam int DivCntW     = $clog2(DivNW);
  localparam int MagW        = 33;
  localparam int ProdW       = 2 * MagW;

  // pi in Q.30, rounded
  localparam logic [31:0] PiQ = 32'hC90FDAA2;
  // CORDIC start x: gain 0x9B74EDA8 (Q0.32) moved to Q.30
  localparam logic signed [ChebW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [ChebW-1:0] ChebOne    = 34'sd1073741824;
  localparam logic signed [SumW-1:0]  SumOne     = 40'sd1073741824;
  localparam logic [WeightW-1:0] WeightMax = 31'h7FFF_FFFF;
  localparam logic [WeightW-1:0] WeightOne = 31'd1073741824;

  // arctan(2^-k) in Q.30
  function automatic logic [AngW-1:0] atan_q(input logic [StepW-1:0] k);
    logic [AngW-1:0] r;
    unique case (k)
      5'd0:    r = 33'd843314857;
      5'd1:    r = 33'd497837829;
      5'd2:    r = 33'd263043837;
      5'd3:    r = 33'd133525159;
      5'd4:    r = 33'd67021687;
      5'd5:    r = 33'd33543516;
      5'd6:    r = 33'd16775851;
      5'd7:    r = 33'd8388437;
      5'd8:    r = 33'd4194283;
      5'd9:    r = 33'd2097149;
      5'd31:   r = 33'd1;
      default: r = 33'd1 << (StepW'(FracBits) - k);
    endcase
    return r;
  endfunction

  typedef enum logic [3:0] {
    S_IDLE, S_ONE, S_FACT_GO, S_FACT_WAIT, S_ANG_GO, S_ANG_WAIT, S_CORDIC, S_SEED,
    S_MUL1, S_CK, S_MUL2, S_ACC, S_WRD, S_WGO, S_WDIV, S_WOUT
  } ccw_state_e;

  typedef enum logic [1:0] {DIV_FACTOR, DIV_ANGLE, DIV_WEIGHT} ccw_div_sel_e;

  typedef enum logic [1:0] {MUL_NONE, MUL_CHEB, MUL_TERM} ccw_mul_sel_e;

  typedef struct packed {
    logic              div_go;
    ccw_div_sel_e      div_sel;
    logic              take_factor;
    logic              cordic_go;
    logic              seed;
    ccw_mul_sel_e      mul_sel;
    logic              step_cheb;
    logic              t_from_cos;
    logic              mem_rd;
    logic              acc;
    logic              first;
    logic              sums_zero;
    logic              out_load;
    logic              out_one;
    logic              double_w;
    logic              last;
    logic [IndexW-1:0] m;
    logic [HalfW-1:0]  i;
    logic [AddrW-1:0]  addr;
    logic [IndexW-1:0] k;
  } ccw_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cordic_done;
    logic out_free;
  } ccw_status_t;

endpackage

@@ src/ccw_div.sv @@
module ccw_div import ccw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] dividend_i,
  input  logic [DivDW-1:0] divisor_i,
  output logic             done_o,
  output logic [DivNW-1:0] quotient_o
);

  logic               run_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivNW-1:0]   quo_q;
  logic [DivDW-1:0]   rem_q, dvs_q;
  logic [DivDW:0]     shifted, diff;
  logic               ge;
  logic [DivDW-1:0]   rem_d;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_q, quo_q[DivNW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};
  assign rem_d   = ge ? diff[DivDW-1:0] : shifted[DivDW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DivCntW'(DivNW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DivNW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ src/ccw_cordic.sv @@
module ccw_cordic import ccw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [AngW-1:0]  angle_i,
  output logic                    done_o,
  output logic signed [ChebW-1:0] cos_o
);

  logic                    run_q, done_q;
  logic [StepW-1:0]        k_q;
  logic signed [ChebW-1:0] x_q, y_q, xs, ys;
  logic signed [AngW-1:0]  z_q, at;

  function automatic logic signed [ChebW-1:0] shr_tz(input logic signed [ChebW-1:0] v,
                                                     input logic [StepW-1:0] k);
    logic [ChebW-1:0] u;
    u = v[ChebW-1] ? -v : v;
    u = u >> k;
    return v[ChebW-1] ? -$signed(u) : $signed(u);
  endfunction

  assign xs = shr_tz(x_q, k_q);
  assign ys = shr_tz(y_q, k_q);
  assign at = $signed(atan_q(k_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        k_q   <= '0;
      end else if (run_q) begin
        k_q <= k_q + 1'b1;
        if (k_q == StepW'(CordicSteps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CordicGain;
      y_q <= '0;
      z_q <= angle_i;
    end else if (run_q) begin
      if (!z_q[AngW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = x_q;

endmodule

@@ src/ccw_datapath.sv @@
module ccw_datapath import ccw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ccw_cmd_t           cmd_i,
  output ccw_status_t        status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IndexW-1:0]  node_index_o,
  output logic [WeightW-1:0] weight_o,
  output logic               last_o
);

  logic [DivNW-1:0]   div_num, quo;
  logic [DivDW-1:0]   div_den;
  logic               div_done, cordic_done;
  logic signed [ChebW-1:0] cordic_x;

  logic [WeightW-1:0]      factor_q;
  logic signed [ChebW-1:0] cos_q, prev_q, prev2_q, t_q;
  logic [ProdW-1:0]        p_q;
  logic                    pneg_q;
  logic signed [SumW-1:0]  sums_mem [SumDepth];
  logic signed [SumW-1:0]  rd_q;

  logic                    out_valid_q, out_last_q;
  logic [IndexW-1:0]       out_index_q;
  logic [WeightW-1:0]      out_weight_q;

  // divider operand sources
  logic [2*HalfW-1:0]    i_sq;
  logic [DivDW-1:0]      den;
  logic                  fac_c1;
  logic [DivNW-1:0]      fac_num;
  logic                  ang_lo;
  logic [IndexW-1:0]     ang_n;
  logic [DivNW:0]        ang_prod;
  logic [DivNW-1:0]      ang_num;
  logic signed [SumW-1:0] s_val, v_val;
  logic [SumW-1:0]       v_pos;
  logic [DivNW-1:0]      w_num;

  assign i_sq    = cmd_i.i * cmd_i.i;
  assign den     = {i_sq, 2'b00} - DivDW'(1);
  assign fac_c1  = !cmd_i.m[0] && (cmd_i.i == HalfW'(cmd_i.m >> 1));
  assign fac_num = (fac_c1 ? (DivNW'(1) << FracBits) : (DivNW'(1) << (FracBits + 1)))
                 + DivNW'(den >> 1);

  // fold the angle into the first quadrant: cos(pi - x) = -cos(x)
  assign ang_lo   = {cmd_i.i, 2'b00} <= {1'b0, cmd_i.m};
  assign ang_n    = ang_lo ? {cmd_i.i, 1'b0} : cmd_i.m - {cmd_i.i, 1'b0};
  assign ang_prod = PiQ * ang_n;
  assign ang_num  = ang_prod[DivNW-1:0] + DivNW'(cmd_i.m >> 1);

  assign s_val = cmd_i.sums_zero ? '0 : rd_q;
  assign v_val = SumOne - s_val;
  assign v_pos = v_val[SumW-1] ? '0 : v_val;
  assign w_num = (cmd_i.double_w ? {v_pos[DivNW-2:0], 1'b0} : v_pos[DivNW-1:0])
               + DivNW'(cmd_i.m);

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_ANGLE: begin
        div_num = ang_num;
        div_den = DivDW'(cmd_i.m);
      end
      DIV_WEIGHT: begin
        div_num = w_num;
        div_den = DivDW'({cmd_i.m, 1'b0});
      end
      default: begin
        div_num = fac_num;
        div_den = den;
      end
    endcase
  end

  ccw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  ccw_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_go),
    .angle_i ($signed(quo[AngW-1:0])),
    .done_o  (cordic_done),
    .cos_o   (cordic_x)
  );

  // sign-magnitude multiply, rounded to nearest with ties away from zero
  function automatic logic [MagW-1:0] mag_of(input logic signed [ChebW-1:0] v);
    logic [ChebW-1:0] u;
    u = v[ChebW-1] ? -v : v;
    return u[MagW-1:0];
  endfunction

  logic [MagW-1:0]          mul_a, mul_b;
  logic                     mul_neg;
  logic [ProdW-1:0]         p_rnd;
  logic [ProdW-FracBits-1:0] r_mag;
  logic signed [SumW-1:0]   r_term, ck_wide, acc_val;
  logic signed [ChebW-1:0]  ck, seed_cos;

  always_comb begin
    if (cmd_i.mul_sel == MUL_CHEB) begin
      mul_a   = mag_of(cos_q);
      mul_b   = mag_of(prev_q);
      mul_neg = cos_q[ChebW-1] ^ prev_q[ChebW-1];
    end else begin
      mul_a   = MagW'(factor_q);
      mul_b   = mag_of(t_q);
      mul_neg = t_q[ChebW-1];
    end
  end

  assign p_rnd   = p_q + (ProdW'(1) << (FracBits - 1));
  assign r_mag   = p_rnd[ProdW-1:FracBits];
  assign r_term  = pneg_q ? -$signed(SumW'(r_mag)) : $signed(SumW'(r_mag));
  assign ck_wide = (r_term <<< 1) - SumW'(prev2_q);
  assign ck      = ck_wide[ChebW-1:0];
  assign acc_val = cmd_i.first ? r_term : rd_q + r_term;
  assign seed_cos = ang_lo ? cordic_x : -cordic_x;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_factor) factor_q <= quo[WeightW-1:0];
    if (cmd_i.mul_sel != MUL_NONE) begin
      p_q    <= mul_a * mul_b;
      pneg_q <= mul_neg;
    end
    if (cmd_i.seed) begin
      cos_q   <= seed_cos;
      prev_q  <= seed_cos;
      prev2_q <= ChebOne;
      t_q     <= ChebOne;
    end else if (cmd_i.step_cheb) begin
      t_q     <= ck;
      prev_q  <= ck;
      prev2_q <= prev_q;
    end else if (cmd_i.t_from_cos) begin
      t_q <= cos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) sums_mem[cmd_i.addr] <= acc_val;
    if (cmd_i.mem_rd) rd_q <= sums_mem[cmd_i.addr];
  end

  // output register
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load && out_free) begin
      if (cmd_i.out_one) begin
        out_index_q  <= '0;
        out_weight_q <= WeightOne;
        out_last_q   <= 1'b1;
      end else begin
        out_index_q  <= cmd_i.k;
        out_weight_q <= (quo > DivNW'(WeightMax)) ? WeightMax : quo[WeightW-1:0];
        out_last_q   <= cmd_i.last;
      end
    end
  end

  assign status_o.div_done    = div_done;
  assign status_o.cordic_done = cordic_done;
  assign status_o.out_free    = out_free;

  assign out_valid_o  = out_valid_q;
  assign node_index_o = out_index_q;
  assign weight_o     = out_weight_q;
  assign last_o       = out_last_q;

endmodule

@@ src/ccw_ctrl.sv @@
module ccw_ctrl import ccw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CountW-1:0] node_count_i,
  input  ccw_status_t       status_i,
  output ccw_cmd_t          cmd_o
);

  ccw_state_e        state_q, state_d;
  logic [IndexW-1:0] m_q, m_d, k_q, k_d, jj, m_new;
  logic [HalfW-1:0]  half_q, half_d, i_q, i_d, j_q, j_d;

  assign m_new = IndexW'(node_count_i - CountW'(1));

  // mirror node index onto the stored half
  always_comb begin
    jj = m_q - k_q;
    if (jj > IndexW'(half_q)) jj = k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      m_q     <= '0;
      half_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
      half_q  <= half_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    half_d  = half_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_FACTOR;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.m       = m_q;
    cmd_o.i       = i_q;
    cmd_o.k       = k_q;
    cmd_o.addr    = AddrW'(j_q);
    in_stall_o    = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (node_count_i == CountW'(1)) begin
            state_d = S_ONE;
          end else if (node_count_i >= CountW'(2) &&
                       node_count_i <= CountW'(MaxNodes)) begin
            m_d    = m_new;
            half_d = HalfW'(m_new >> 1);
            i_d    = HalfW'(1);
            k_d    = '0;
            state_d = (m_new >> 1) == '0 ? S_WRD : S_FACT_GO;
          end
        end
      end
      S_ONE: begin
        cmd_o.out_one  = 1'b1;
        cmd_o.out_load = 1'b1;
        if (status_i.out_free) state_d = S_IDLE;
      end
      S_FACT_GO: begin
        cmd_o.div_go = 1'b1;
        state_d      = S_FACT_WAIT;
      end
      S_FACT_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.take_factor = 1'b1;
          state_d           = S_ANG_GO;
        end
      end
      S_ANG_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_ANGLE;
        state_d       = S_ANG_WAIT;
      end
      S_ANG_WAIT: begin
        cmd_o.div_sel = DIV_ANGLE;
        if (status_i.div_done) begin
          cmd_o.cordic_go = 1'b1;
          state_d         = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cmd_o.div_sel = DIV_ANGLE;
        if (status_i.cordic_done) state_d = S_SEED;
      end
      S_SEED: begin
        cmd_o.div_sel = DIV_ANGLE;
        cmd_o.seed    = 1'b1;
        j_d           = '0;
        state_d       = S_MUL2;
      end
      S_MUL1: begin
        cmd_o.mul_sel = MUL_CHEB;
        state_d       = S_CK;
      end
      S_CK: begin
        cmd_o.step_cheb = 1'b1;
        state_d         = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_sel = MUL_TERM;
        cmd_o.mem_rd  = 1'b1;
        state_d       = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc   = 1'b1;
        cmd_o.first = (i_q == HalfW'(1));
        if (j_q == half_q) begin
          if (i_q == half_q) begin
            k_d     = '0;
            state_d = S_WRD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_FACT_GO;
          end
        end else begin
          j_d = j_q + 1'b1;
          if (j_q == '0) begin
            cmd_o.t_from_cos = 1'b1;
            state_d          = S_MUL2;
          end else begin
            state_d = S_MUL1;
          end
        end
      end
      S_WRD: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.addr   = AddrW'(jj);
        state_d      = S_WGO;
      end
      S_WGO: begin
        cmd_o.div_go    = 1'b1;
        cmd_o.div_sel   = DIV_WEIGHT;
        cmd_o.sums_zero = (half_q == '0);
        cmd_o.double_w  = (k_q != '0) && (k_q != m_q);
        state_d         = S_WDIV;
      end
      S_WDIV: begin
        cmd_o.div_sel = DIV_WEIGHT;
        if (status_i.div_done) state_d = S_WOUT;
      end
      S_WOUT: begin
        cmd_o.div_sel  = DIV_WEIGHT;
        cmd_o.out_load = 1'b1;
        cmd_o.last     = (k_q == m_q);
        if (status_i.out_free) begin
          if (k_q == m_q) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_WRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ src/clenshaw_curtis_weight_generator_unit.sv @@
// Clenshaw-Curtis weights on [0,1], one request of n nodes in, n weight beats out
// (none for n > 64). The shared divider and the 32-step CORDIC set the per-row
// cost, the multiply-accumulate step (MUL1, CK, MUL2, ACC) sets the inner loop.
// n = 1 answers with a single beat of weight 1.0.
// Throughput: one request at a time; a new request is taken once the last beat is queued.
// Reset: asynchronous, active low; clears control and the output valid, not the sums.
module clenshaw_curtis_weight_generator_unit import ccw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CountW-1:0]  node_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IndexW-1:0]  node_index_o,
  output logic [WeightW-1:0] weight_o,
  output logic               last_o
);

  ccw_cmd_t    cmd;
  ccw_status_t status;

  // Controller walks rows i, columns j of the cosine sums, then emits weights k.
  ccw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .node_count_i (node_count_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Datapath holds the divider, CORDIC, multiplier, sum memory and output register.
  ccw_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .node_index_o (node_index_o),
    .weight_o     (weight_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  // a request with work to do keeps the input side stalled next cycle
  a_busy_after_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (node_count_i >= CountW'(2)) &&
    (node_count_i <= CountW'(MaxNodes)) |=> in_stall_o)
    else $error("request accepted but block did not go busy");

  // a single-beat answer is the one-node case and carries weight 1.0
  a_single_weight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && (node_index_o == '0) |-> weight_o == WeightOne)
    else $error("one-node weight is not 1.0");
`endif

endmodule

@@ sim/tb_clenshaw_curtis_weight_generator_unit.sv @@
`timescale 1ns / 100ps

module tb_clenshaw_curtis_weight_generator_unit;
  import ccw_pkg::*;

  typedef struct {
    logic [IndexW-1:0]  node_index;
    logic [WeightW-1:0] weight;
    logic               last;
  } weight_beat_t;

  // Fixed-point constants of the weight math
  localparam int F = FracBits;
  localparam longint unsigned PiQ60 = 64'h3243F6A8885A308D;
  localparam longint unsigned GainQ32 = 64'h9B74EDA8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CountW-1:0] node_count_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [IndexW-1:0] node_index_o;
  logic [WeightW-1:0] weight_o;
  logic last_o;

  // Requests waiting to be sent, and weights still owed by the block
  logic [CountW-1:0] count_queue[$];
  int gap_queue[$];
  weight_beat_t weight_queue[$];
  int err_count = 0;
  bit send_done = 1'b0;
  bit hold_drain = 1'b0;
  longint sums[SumDepth];

  clenshaw_curtis_weight_generator_unit uut (.*);

  always #5 clk_i = ~clk_i;

  // Arithmetic helpers, all on 64-bit signed magnitudes
  function automatic longint unsigned rnd_down(longint unsigned v, int from);
    if (from > F) return (v + (64'd1 << (from - F - 1))) >> (from - F);
    return v << (F - from);
  endfunction

  // Round-to-nearest Q.F product, ties away from zero
  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    longint unsigned ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = ({64'd0, ma} * {64'd0, mb} + (128'd1 << (F - 1))) >> F;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint shr_tz(longint v, int k);
    return (v < 0) ? -(longint'((-v) >>> k)) : (v >>> k);
  endfunction

  function automatic longint arctan_step(int k);
    longint unsigned acc;
    int e;
    if (k == 0) return rnd_down(PiQ60, 62);
    acc = 0;
    for (int j = 0; j < 32; j++) begin
      e = 62 - k * (2 * j + 1);
      if (e < 0) break;
      if (j & 1) acc -= (64'd1 << e) / (2 * j + 1);
      else acc += (64'd1 << e) / (2 * j + 1);
    end
    return rnd_down(acc, 62);
  endfunction

  // cos(pi * num / m) by CORDIC rotation
  function automatic longint cos_pi_frac(longint unsigned num, longint unsigned m);
    longint z, x, y, nx;
    z = (rnd_down(PiQ60, 60) * num + m / 2) / m;
    x = rnd_down(GainQ32, 32);
    y = 0;
    for (int k = 0; k < F + 2; k++) begin
      if (z >= 0) begin
        nx = x - shr_tz(y, k);
        y = y + shr_tz(x, k);
        z -= arctan_step(k);
      end else begin
        nx = x + shr_tz(y, k);
        y = y - shr_tz(x, k);
        z += arctan_step(k);
      end
      x = nx;
    end
    return x;
  endfunction

  // Queue the weights that one request of n nodes must produce
  task automatic predict_weights(int n);
    int m, half, jj;
    longint one, factor, cosv, tprev, tprev2, ck, v;
    longint unsigned c, den, w;
    weight_beat_t b;
    one = longint'(1) << F;
    if (n == 0 || n > MaxNodes) return;
    if (n == 1) begin
      b.node_index = '0;
      b.weight = WeightOne;
      b.last = 1'b1;
      weight_queue.push_back(b);
      return;
    end
    m = n - 1;
    half = m / 2;
    foreach (sums[j]) sums[j] = 0;
    for (int i = 1; i <= half; i++) begin
      c = (m % 2 == 0 && i == half) ? 1 : 2;
      den = 4 * i * i - 1;
      factor = ((c << F) + den / 2) / den;
      cosv = (4 * i <= m) ? cos_pi_frac(2 * i, m) : -cos_pi_frac(m - 2 * i, m);
      tprev = cosv;
      tprev2 = one;
      sums[0] += fx_mul(factor, tprev2);
      sums[1] += fx_mul(factor, tprev);
      for (int j = 2; j <= half && j < SumDepth; j++) begin
        ck = 2 * fx_mul(cosv, tprev) - tprev2;
        sums[j] += fx_mul(factor, ck);
        tprev2 = tprev;
        tprev = ck;
      end
    end
    for (int k = 0; k <= m; k++) begin
      jj = m - k;
      if (jj > half) jj = m - jj;
      v = one - sums[jj];
      if (v < 0) v = 0;
      c = (k == 0 || k == m) ? 1 : 2;
      den = 2 * m;
      w = (longint'(v) * c + den / 2) / den;
      if (w > WeightMax) w = WeightMax;
      b.node_index = k[IndexW-1:0];
      b.weight = w[WeightW-1:0];
      b.last = (k == m);
      weight_queue.push_back(b);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Driver: present one request per beat, with a drawn gap after each
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_weights(node_count_i);
        count_queue.pop_front();
        gap_left = gap_queue.pop_front();
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled beat
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (count_queue.size() > 0 && !(hold_drain && weight_queue.size() > 0)) begin
        in_valid_i <= 1'b1;
        node_count_i <= count_queue[0];
      end else begin
        in_valid_i <= 1'b0;
        if (count_queue.size() == 0) send_done = 1'b1;
      end
    end
  end

  // Monitor: check each accepted weight beat, draw the next stall
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (weight_queue.size() == 0) begin
          report_mismatch("unexpected beat, index", node_index_o, -1);
        end else begin
          weight_beat_t e;
          e = weight_queue.pop_front();
          if (node_index_o !== e.node_index) report_mismatch("index", node_index_o, e.node_index);
          if (weight_o !== e.weight) report_mismatch("weight", weight_o, e.weight);
          if (last_o !== e.last) report_mismatch("last", last_o, e.last);
        end
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic add_request(int n);
    count_queue.push_back(n[CountW-1:0]);
    gap_queue.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4));
  endtask

  initial begin
    // directed: empty, single node, over-range, extremes, even and odd sizes
    add_request(0);
    add_request(1);
    add_request(2);
    add_request(3);
    add_request(4);
    add_request(5);
    add_request(64);
    add_request(65);
    add_request(127);
    add_request(63);
    add_request(33);
    add_request(32);
    add_request(1);
    add_request(0);
    add_request(96);
    // random: mostly small counts, a few large, some out of range
    for (int i = 0; i < 145; i++) begin
      case ($urandom_range(0, 9))
        0: add_request($urandom_range(65, 127));
        1, 2: add_request($urandom_range(33, 64));
        3: add_request($urandom_range(0, 1));
        default: add_request($urandom_range(2, 16));
      endcase
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // pause the sender once until all weights are in
    wait (count_queue.size() < 120 && weight_queue.size() > 0);
    hold_drain = 1'b1;
    wait (weight_queue.size() == 0);
    @(posedge clk_i);
    hold_drain = 1'b0;
    wait (send_done && !in_valid_i);
    wait (weight_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ clenshaw_curtis_weight_generator_unit.f @@
src/ccw_pkg.sv
src/ccw_div.sv
src/ccw_cordic.sv
src/ccw_datapath.sv
src/ccw_ctrl.sv
src/clenshaw_curtis_weight_generator_unit.sv
sim/tb_clenshaw_curtis_weight_generator_unit.sv
